/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked at every edge outside reset
`define BPS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bps assertion failed");
// property checked at every edge, reset included
`define BPS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("bps assertion failed");
`else
`define BPS_ASSERT(label, clk, rst_n, prop)
`define BPS_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* src/bps_pkg.sv */
// ----------------------------------------------------------------------------
// bps_pkg
// shared sizes, beat types, codes and helpers of the bucketed priority stack
// ----------------------------------------------------------------------------
package bps_pkg;

    localparam int CAPACITY   = 256;
    localparam int LEVELS     = 16;
    localparam int ELEM_WIDTH = 32;

    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int LEVEL_W = $clog2(LEVELS);
    localparam int COUNT_W = SLOT_W + 1;

    // slot pointer with a null code one above the last slot
    localparam logic [COUNT_W-1:0] NULL_SLOT = COUNT_W'(CAPACITY);

    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_POP  = 2'd1;
    localparam logic [1:0] MODE_PEEK = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_PRIO  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]            mode;
        logic [ELEM_WIDTH-1:0] elem;
        logic [LEVEL_W-1:0]    priority_req;
    } cmd_t;

    typedef struct packed {
        status_t               status;
        logic [ELEM_WIDTH-1:0] top_elem;
        logic [LEVEL_W-1:0]    top_priority;
        logic [COUNT_W-1:0]    count;
        logic                  is_empty;
    } result_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_FREE,
        S_PUSH_WR,
        S_POP_HEAD,
        S_POP_LINK,
        S_POP_NEWHEAD,
        S_POP_ELEM,
        S_RESP
    } state_t;

    // highest set bit of the level occupancy mask, 0 when none
    function automatic logic [LEVEL_W-1:0] top_level(input logic [LEVELS-1:0] ne);
        logic [LEVEL_W-1:0] lv;
        lv = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (ne[i])
            begin
                lv = LEVEL_W'(i);
            end
        end
        return lv;
    endfunction

endpackage

/* src/bucketed_priority_stack_unit.sv */
// ----------------------------------------------------------------------------
// bucketed_priority_stack_unit
// priority stack: one lifo list per level over a shared element store
// ----------------------------------------------------------------------------
//
// channel   | signals                       | direction | handshake
// ----------+-------------------------------+-----------+---------------------------
// command   | start, busy, cmd              | in        | beat when start & !busy
// result    | done, result                  | out       | one-cycle strobe, no stall
// config    | cfg_valid, cfg_ready, cfg_data| in        | beat when valid & ready
//
// sequence: peek, errors and empty stores go straight to done; a push from a
//   never-used slot writes at once, a push into a recycled slot first reads
//   its free list link; a pop reads head, link and element, skips the element
//   read when it empties the store, and reads head, link, head, element in
//   sequence when it empties its level while a lower level holds data, all on
//   the registered-read stores. busy drops in the cycle after done.
// reset: async active low; no memory clearing pass, and a never-written entry
//   is read only as a head that a push ignores, so the block is ready right
//   after reset. the result receiver cannot stall; cfg_ready is always high.
//
module bucketed_priority_stack_unit (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  bps_pkg::cmd_t            cmd,
    output logic                     done,
    output bps_pkg::result_t         result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [bps_pkg::LEVEL_W-1:0] cfg_data
);
    import bps_pkg::*;

    `include "assert_macros.svh"

    // storage: element values, list links, per-level heads
    logic [ELEM_WIDTH-1:0] elem_mem [CAPACITY];
    logic [SLOT_W-1:0]     link_mem [CAPACITY];
    logic [SLOT_W-1:0]     head_mem [LEVELS];

    // memory ports
    logic                  elem_we, elem_re;
    logic [SLOT_W-1:0]     elem_waddr, elem_raddr;
    logic [ELEM_WIDTH-1:0] elem_rdata_reg;
    logic                  link_we, link_re;
    logic [SLOT_W-1:0]     link_waddr, link_raddr, link_wdata;
    logic [SLOT_W-1:0]     link_rdata_reg;
    logic                  head_we, head_re;
    logic [LEVEL_W-1:0]    head_waddr, head_raddr;
    logic [SLOT_W-1:0]     head_wdata;
    logic [SLOT_W-1:0]     head_rdata_reg;

    // control state
    state_t                state_reg, state_next;
    logic [LEVEL_W-1:0]    max_prio_reg;
    logic [LEVELS-1:0]     nonempty_reg, nonempty_next;
    logic [COUNT_W-1:0]    free_head_reg, free_head_next;
    logic [COUNT_W-1:0]    fresh_reg, fresh_next;
    logic [COUNT_W-1:0]    count_reg, count_next;

    // per-item working registers
    cmd_t                  cmd_reg;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic                  use_free_reg, use_free_next;
    status_t               status_reg, status_next;
    logic [ELEM_WIDTH-1:0] top_elem_reg, top_elem_next;

    logic [LEVEL_W-1:0]    top_lv;
    logic                  store_empty;
    logic                  free_valid;

    assign top_lv      = top_level(nonempty_reg);
    assign store_empty = (nonempty_reg == '0);
    assign free_valid  = !free_head_reg[SLOT_W];

    // memories: synchronous write, registered read
    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[elem_waddr] <= cmd_reg.elem;
        end
        if (elem_re)
        begin
            elem_rdata_reg <= elem_mem[elem_raddr];
        end
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (link_re)
        begin
            link_rdata_reg <= link_mem[link_raddr];
        end
        if (head_we)
        begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (head_re)
        begin
            head_rdata_reg <= head_mem[head_raddr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            max_prio_reg  <= LEVEL_W'(LEVELS - 1);
            nonempty_reg  <= '0;
            free_head_reg <= NULL_SLOT;
            fresh_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            nonempty_reg  <= nonempty_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            count_reg     <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                max_prio_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
        end
        slot_reg     <= slot_next;
        use_free_reg <= use_free_next;
        status_reg   <= status_next;
        top_elem_reg <= top_elem_next;
    end

    // sequencer: next state, memory accesses, state updates
    always_comb
    begin
        state_next     = state_reg;
        nonempty_next  = nonempty_reg;
        free_head_next = free_head_reg;
        fresh_next     = fresh_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        use_free_next  = use_free_reg;
        status_next    = status_reg;
        top_elem_next  = top_elem_reg;

        elem_we    = 1'b0;
        elem_re    = 1'b0;
        elem_waddr = slot_reg;
        elem_raddr = link_rdata_reg;
        link_we    = 1'b0;
        link_re    = 1'b0;
        link_waddr = slot_reg;
        link_raddr = slot_reg;
        link_wdata = slot_reg;
        head_we    = 1'b0;
        head_re    = 1'b0;
        head_waddr = top_lv;
        head_raddr = top_lv;
        head_wdata = slot_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next = ST_OK;
                    if (cmd.mode == MODE_PUSH)
                    begin
                        if (cmd.priority_req > max_prio_reg)
                        begin
                            status_next = ST_PRIO;
                            state_next  = S_RESP;
                        end
                        else if (count_reg == COUNT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            // head of the target level, needed as the new link
                            head_re    = 1'b1;
                            head_raddr = cmd.priority_req;
                            use_free_next = free_valid;
                            if (free_valid)
                            begin
                                slot_next  = free_head_reg[SLOT_W-1:0];
                                link_re    = 1'b1;
                                link_raddr = free_head_reg[SLOT_W-1:0];
                                state_next = S_PUSH_FREE;
                            end
                            else
                            begin
                                slot_next  = fresh_reg[SLOT_W-1:0];
                                state_next = S_PUSH_WR;
                            end
                        end
                    end
                    else if (store_empty)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_RESP;
                    end
                    else if (cmd.mode == MODE_POP)
                    begin
                        head_re    = 1'b1;
                        head_raddr = top_lv;
                        state_next = S_POP_HEAD;
                    end
                    else
                    begin
                        // peek and the unused mode answer from the cached top
                        state_next = S_RESP;
                    end
                end
            end

            S_PUSH_FREE:
            begin
                // unlink the recycled slot from the free list
                if (link_rdata_reg == slot_reg)
                begin
                    free_head_next = NULL_SLOT;
                end
                else
                begin
                    free_head_next = {1'b0, link_rdata_reg};
                end
                state_next = S_PUSH_WR;
            end

            S_PUSH_WR:
            begin
                elem_we    = 1'b1;
                link_we    = 1'b1;
                link_wdata = nonempty_reg[cmd_reg.priority_req] ? head_rdata_reg : slot_reg;
                head_we    = 1'b1;
                head_waddr = cmd_reg.priority_req;
                head_wdata = slot_reg;
                nonempty_next[cmd_reg.priority_req] = 1'b1;
                count_next = count_reg + COUNT_W'(1);
                if (!use_free_reg)
                begin
                    fresh_next = fresh_reg + COUNT_W'(1);
                end
                if (store_empty || (cmd_reg.priority_req >= top_lv))
                begin
                    top_elem_next = cmd_reg.elem;
                end
                state_next = S_RESP;
            end

            S_POP_HEAD:
            begin
                slot_next  = head_rdata_reg;
                link_re    = 1'b1;
                link_raddr = head_rdata_reg;
                state_next = S_POP_LINK;
            end

            S_POP_LINK:
            begin
                // drop the top slot from its level
                if (link_rdata_reg == slot_reg)
                begin
                    nonempty_next[top_lv] = 1'b0;
                end
                else
                begin
                    head_we    = 1'b1;
                    head_waddr = top_lv;
                    head_wdata = link_rdata_reg;
                end
                // and give it back to the free list
                link_we        = 1'b1;
                link_waddr     = slot_reg;
                link_wdata     = free_valid ? free_head_reg[SLOT_W-1:0] : slot_reg;
                free_head_next = {1'b0, slot_reg};
                count_next     = count_reg - COUNT_W'(1);

                if (nonempty_next == '0)
                begin
                    state_next = S_RESP;
                end
                else if (link_rdata_reg != slot_reg)
                begin
                    // same level stays on top, its new head is the link
                    elem_re    = 1'b1;
                    elem_raddr = link_rdata_reg;
                    state_next = S_POP_ELEM;
                end
                else
                begin
                    head_re    = 1'b1;
                    head_raddr = top_level(nonempty_next);
                    state_next = S_POP_NEWHEAD;
                end
            end

            S_POP_NEWHEAD:
            begin
                elem_re    = 1'b1;
                elem_raddr = head_rdata_reg;
                state_next = S_POP_ELEM;
            end

            S_POP_ELEM:
            begin
                top_elem_next = elem_rdata_reg;
                state_next    = S_RESP;
            end

            S_RESP:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ports
    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_RESP);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        result.status       = status_reg;
        result.top_elem     = store_empty ? '0 : top_elem_reg;
        result.top_priority = store_empty ? '0 : top_lv;
        result.count        = count_reg;
        result.is_empty     = store_empty;
    end

    // checks
    `BPS_ASSERT(a_count_range, clk, rst_n, count_reg <= COUNT_W'(CAPACITY))
    `BPS_ASSERT(a_count_vs_levels, clk, rst_n, (count_reg == '0) == (nonempty_reg == '0))
    `BPS_ASSERT(a_fresh_range, clk, rst_n, fresh_reg <= COUNT_W'(CAPACITY))
    `BPS_ASSERT(a_start_busy, clk, rst_n, (start && !busy) |=> busy)
    `BPS_ASSERT(a_full_code, clk, rst_n,
        (done && result.status == ST_FULL) |-> (count_reg == COUNT_W'(CAPACITY)))

endmodule

/* tb/bucketed_priority_stack_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bucketed_priority_stack_unit_test
// self-checking bench for the priority stack: a local model of the level
// lists and free list predicts every result beat, a monitor compares each
// done beat field by field; directed corner cases first, then a full
// fill and drain and random push/pop/peek traffic under several maximums
// ----------------------------------------------------------------------------
module bucketed_priority_stack_unit_test;

    import bps_pkg::*;

    // unused mode code, handled by the block as a peek
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 8;
    // worst case is the longest block command plus the longest sender gap
    // per beat, so this stays far above any correct run
    localparam int LIMIT_CYCLES = 400000;
    // wait longer than the block takes for its longest command
    localparam int SETTLE_CYCLES = 8;

    // ------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                start     = 1'b0;
    logic                busy;
    cmd_t                cmd       = '0;
    logic                done;
    result_t             result;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [LEVEL_W-1:0]  cfg_data  = '0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    bucketed_priority_stack_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // local copy of the stack state
    // a slot whose link points at itself ends its list
    // ------------------------------------------------------------------
    logic [ELEM_WIDTH-1:0] elem_mem  [CAPACITY];
    int                    link_mem  [CAPACITY];
    int                    level_top [LEVELS];
    bit                    level_used[LEVELS];
    int                    free_top;
    int                    fresh_next;
    int                    held_count;
    logic [LEVEL_W-1:0]    max_prio;

    result_t pending_results[$];
    int      error_count = 0;
    int      cycle_count = 0;
    // when set the sender inserts no gaps between beats
    bit      steady_run  = 1'b0;

    // highest level holding data, -1 when the store is empty
    function automatic int highest_level();
        for (int lv = LEVELS - 1; lv >= 0; lv--)
        begin
            if (level_used[lv])
            begin
                return lv;
            end
        end
        return -1;
    endfunction

    // applies one command to the local state, returns the result beat it causes
    function automatic result_t predict_stack_step(input cmd_t c);
        result_t r;
        int      lv;
        int      slot;
        int      nxt;
        int      p;
        r        = '0;
        r.status = ST_OK;
        p        = int'(c.priority_req);
        if (c.mode == MODE_PUSH)
        begin
            // priority check wins over the full check
            if (c.priority_req > max_prio)
            begin
                r.status = ST_PRIO;
            end
            else if (held_count >= CAPACITY)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                // recycled slot first, else the next never-used one
                if (free_top != CAPACITY)
                begin
                    slot     = free_top;
                    nxt      = link_mem[slot];
                    free_top = (nxt == slot) ? CAPACITY : nxt;
                end
                else
                begin
                    slot = fresh_next;
                    fresh_next++;
                end
                elem_mem[slot] = c.elem;
                link_mem[slot] = level_used[p] ? level_top[p] : slot;
                level_top[p]   = slot;
                level_used[p]  = 1'b1;
                held_count++;
            end
        end
        else
        begin
            // pop, peek and the spare code all look at the top level,
            // whatever the current maximum is
            lv = highest_level();
            if (lv < 0)
            begin
                r.status = ST_EMPTY;
            end
            else if (c.mode == MODE_POP)
            begin
                slot = level_top[lv];
                nxt  = link_mem[slot];
                if (nxt == slot)
                begin
                    level_used[lv] = 1'b0;
                end
                else
                begin
                    level_top[lv] = nxt;
                end
                link_mem[slot] = (free_top != CAPACITY) ? free_top : slot;
                free_top       = slot;
                held_count--;
            end
        end
        lv = highest_level();
        if (lv >= 0)
        begin
            r.top_elem     = elem_mem[level_top[lv]];
            r.top_priority = LEVEL_W'(lv);
            r.is_empty     = 1'b0;
        end
        else
        begin
            r.is_empty = 1'b1;
        end
        r.count = COUNT_W'(held_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result monitor: every done beat is matched against the oldest
    // prediction, the receiver never stalls
    // ------------------------------------------------------------------
    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: result beat with nothing expected, actual %h", $time, result);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                    report_field("status", 32'(want.status), 32'(result.status));
                if (result.top_elem !== want.top_elem)
                    report_field("top_elem", 32'(want.top_elem), 32'(result.top_elem));
                if (result.top_priority !== want.top_priority)
                    report_field("top_priority", 32'(want.top_priority),
                                 32'(result.top_priority));
                if (result.count !== want.count)
                    report_field("count", 32'(want.count), 32'(result.count));
                if (result.is_empty !== want.is_empty)
                    report_field("is_empty", 32'(want.is_empty), 32'(result.is_empty));
            end
        end
    end

    // watchdog on the total run length
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: run did not finish in %0d cycles", $time, LIMIT_CYCLES);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (steady_run)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // sends one command beat; start stays high when the next beat follows
    // without a gap so it is never dropped and raised in one step
    task automatic send_cmd(input cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        // beat taken at this edge
        pending_results.push_back(predict_stack_step(c));
    endtask

    function automatic cmd_t make_cmd(input logic [1:0] mode,
                                      input logic [ELEM_WIDTH-1:0] elem,
                                      input logic [LEVEL_W-1:0] prio);
        cmd_t c;
        c.mode         = mode;
        c.elem         = elem;
        c.priority_req = prio;
        return c;
    endfunction

    // pop or peek with random don't-care fields
    task automatic send_op(input logic [1:0] mode);
        send_cmd(make_cmd(mode, $urandom(), LEVEL_W'($urandom_range(0, LEVELS - 1))));
    endtask

    // holds the sender until every predicted beat has come back
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // register write only on an idle block
    task automatic write_max_priority(input logic [LEVEL_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid <= 1'b0;
        max_prio = value;
    endtask

    // random traffic beat: push heavy so the store fills up over time,
    // priorities mostly legal for the current maximum
    function automatic cmd_t random_cmd();
        int               r;
        logic [1:0]       mode;
        logic [LEVEL_W-1:0] prio;
        r = $urandom_range(0, 99);
        if (r < 50)
            mode = MODE_PUSH;
        else if (r < 82)
            mode = MODE_POP;
        else if (r < 94)
            mode = MODE_PEEK;
        else
            mode = MODE_SPARE;
        if ($urandom_range(0, 99) < 85)
            prio = LEVEL_W'($urandom_range(0, int'(max_prio)));
        else
            prio = LEVEL_W'($urandom_range(0, LEVELS - 1));
        return make_cmd(mode, $urandom(), prio);
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // pop, peek and the spare code on an empty store
    task automatic test_empty_store();
        send_op(MODE_POP);
        send_op(MODE_PEEK);
        send_op(MODE_SPARE);
    endtask

    // field extremes and last-in-first-out order within a level
    task automatic test_level_order();
        send_cmd(make_cmd(MODE_PUSH, 32'h0000_0000, 4'd0));
        send_cmd(make_cmd(MODE_PUSH, 32'hFFFF_FFFF, 4'd15));
        send_cmd(make_cmd(MODE_PUSH, 32'hA5A5_A5A5, 4'd15));
        send_cmd(make_cmd(MODE_PUSH, 32'h5555_5555, 4'd7));
        send_cmd(make_cmd(MODE_PUSH, 32'hAAAA_AAAA, 4'd8));
        send_op(MODE_PEEK);
        send_op(MODE_SPARE);
        // drain through every level, one pop past empty
        repeat (6) send_op(MODE_POP);
        // popped slots come back from the free list
        send_cmd(make_cmd(MODE_PUSH, 32'h1234_5678, 4'd3));
        send_op(MODE_POP);
    endtask

    // a lowered maximum rejects pushes but pops still see the higher levels
    task automatic test_priority_limit();
        send_cmd(make_cmd(MODE_PUSH, 32'hDEAD_0F0F, 4'd15));
        write_max_priority(4'd0);
        send_cmd(make_cmd(MODE_PUSH, 32'h0000_0001, 4'd1));
        send_cmd(make_cmd(MODE_PUSH, 32'h0000_0002, 4'd15));
        send_cmd(make_cmd(MODE_PUSH, 32'h0000_0003, 4'd0));
        send_op(MODE_PEEK);
        send_op(MODE_POP);
        send_op(MODE_POP);
        write_max_priority(4'd15);
    endtask

    // fills every slot, checks the full and priority rejections on a full
    // store, then empties it again through all levels
    task automatic test_fill_and_drain();
        repeat (CAPACITY)
            send_cmd(make_cmd(MODE_PUSH, $urandom(), LEVEL_W'($urandom_range(0, LEVELS - 1))));
        repeat (3)
            send_cmd(make_cmd(MODE_PUSH, $urandom(), LEVEL_W'($urandom_range(0, LEVELS - 1))));
        // priority check comes before the full check
        write_max_priority(4'd7);
        repeat (3)
            send_cmd(make_cmd(MODE_PUSH, $urandom(), LEVEL_W'($urandom_range(8, LEVELS - 1))));
        repeat (2)
            send_cmd(make_cmd(MODE_PUSH, $urandom(), LEVEL_W'($urandom_range(0, 7))));
        while (held_count > 0)
        begin
            if ($urandom_range(0, 9) == 0)
                send_op(MODE_PEEK);
            else
                send_op(MODE_POP);
        end
        send_op(MODE_POP);
    endtask

    // random traffic under one maximum, with no-gap stretches and
    // occasional full pauses of the sender
    task automatic test_random_traffic(input logic [LEVEL_W-1:0] limit, input int beats);
        write_max_priority(limit);
        for (int i = 0; i < beats; i++)
        begin
            if (i % 40 == 0)
                steady_run = ($urandom_range(0, 3) == 0);
            if (i % 120 == 119)
                drain_results();
            send_cmd(random_cmd());
        end
        steady_run = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < LEVELS; i++)
        begin
            level_used[i] = 1'b0;
            level_top[i]  = 0;
        end
        free_top   = CAPACITY;
        fresh_next = 0;
        held_count = 0;
        max_prio   = 4'd15;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_store();
        test_level_order();
        test_priority_limit();
        test_fill_and_drain();
        test_random_traffic(4'd15, 275);
        test_random_traffic(4'd0, 275);
        test_random_traffic(4'd9, 275);
        test_random_traffic(LEVEL_W'($urandom_range(0, LEVELS - 1)), 275);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/bps_pkg.sv
src/bucketed_priority_stack_unit.sv
tb/bucketed_priority_stack_unit_test.sv
